// ===== rtl/core/ssab_pkg.sv =====
// Shared types and constants for the sample splat accumulation buffer
package ssab_pkg;

	localparam int DEF_MAX_COLUMNS = 128;
	localparam int DEF_MAX_ROWS    = 128;
	localparam int SUM_W   = 32;
	localparam int TOTAL_W = 40;
	localparam int COLOR_W = 16;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		OP_STORE   = 2'd0,
		OP_ADD_CNT = 2'd1,
		OP_DEVELOP = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] count_delta;
		logic [6:0]  pixel_col;
		logic [6:0]  pixel_row;
	} in_item_t;

	typedef struct packed {
		logic [15:0] red_out;
		logic [15:0] green_out;
		logic [15:0] blue_out;
		logic        total_was_zero;
	} out_item_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_WRITE,
		BK_DIV,
		BK_CLEAR
	} bk_state_t;

endpackage

// ===== rtl/core/sample_splat_accumulation_buffer.sv =====
// Top level of the sample splat accumulation buffer
// Usage:
//   Commands enter on start/busy with in_item; a command transfers when start
//   is high and busy is low. Store adds a sample color to one pixel's sums,
//   add-count grows the sample total, develop returns one pixel divided by the
//   total, clear zeroes the store and the total.
//   Configuration (frame width/height) is written on cfg_valid/cfg_ready with
//   cfg_index and cfg_data; cfg_ready is always high.
//   A four-entry command queue decouples the front from the back end.
//   Store does one memory read and then one write; add-count updates the total.
//   Develop runs the three colors in turn through the bit-serial divider
//   shared across them; with a zero total it returns zeros without dividing.
//   Clear sweeps all 2^(COL_W + ROW_W) pixels, one pixel per cycle (16384 for
//   the default 128 x 128 frame).
//   Results appear on result/result_valid for one cycle; the receiver cannot
//   stall them.
//   After reset the block sweeps all 2^(COL_W + ROW_W) pixels of the store
//   while queued commands wait; the queue still takes up to four commands.
module sample_splat_accumulation_buffer #(
	parameter int MAX_COLUMNS = ssab_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = ssab_pkg::DEF_MAX_ROWS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ssab_pkg::in_item_t  in_item,
	output logic                result_valid,
	output ssab_pkg::out_item_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data
);
	import ssab_pkg::*;

	localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int AW = COL_W + ROW_W;

	logic [7:0]    fw_q, fh_q;
	logic          q_valid, q_pop;
	logic [1:0]    q_op;
	logic [AW-1:0] q_addr;
	logic [47:0]   q_color;
	logic [15:0]   q_delta;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 8'd128;
			fh_q <= 8'd128;
		end else if (cfg_valid) begin
			if (reg_idx_t'(cfg_index) == REG_WIDTH) fw_q <= cfg_data;
			else fh_q <= cfg_data;
		end
	end

	ssab_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS),
		.COL_W(COL_W), .ROW_W(ROW_W)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.frame_width_q(fw_q), .frame_height_q(fh_q), .q_valid(q_valid), .q_op(q_op),
		.q_addr(q_addr), .q_color(q_color), .q_delta(q_delta), .q_pop(q_pop)
	);

	ssab_back #(.AW(AW)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_op(q_op), .q_addr(q_addr),
		.q_color(q_color), .q_delta(q_delta), .q_pop(q_pop),
		.result_valid(result_valid), .result(result)
	);

endmodule

// ===== rtl/core/ssab_front.sv =====
// Front end: accepts commands, maps positions to pixel addresses, queues work
module ssab_front #(
	parameter int MAX_COLUMNS = ssab_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = ssab_pkg::DEF_MAX_ROWS,
	parameter int COL_W       = 7,
	parameter int ROW_W       = 7
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  ssab_pkg::in_item_t     in_item,
	input  logic [7:0]             frame_width_q,
	input  logic [7:0]             frame_height_q,
	output logic                   q_valid,
	output logic [1:0]             q_op,
	output logic [ROW_W+COL_W-1:0] q_addr,
	output logic [47:0]            q_color,
	output logic [15:0]            q_delta,
	input  logic                   q_pop
);
	import ssab_pkg::*;

	localparam int AW = ROW_W + COL_W;
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int EW = 2 + AW + 48 + 16;

	logic [12:0] w_eff, h_eff;
	logic [12:0] col_c, row_c;
	logic [28:0] px_prod, py_prod;
	logic [12:0] px_idx, py_idx;
	logic [EW-1:0] fifo_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   cnt_q;
	logic [EW-1:0] entry;
	logic          push;

	// clamp configured size to 1..MAX
	always_comb begin
		if (frame_width_q == 8'd0) w_eff = 13'd1;
		else if ({5'd0, frame_width_q} > 13'(MAX_COLUMNS)) w_eff = 13'(MAX_COLUMNS);
		else w_eff = {5'd0, frame_width_q};
		if (frame_height_q == 8'd0) h_eff = 13'd1;
		else if ({5'd0, frame_height_q} > 13'(MAX_ROWS)) h_eff = 13'(MAX_ROWS);
		else h_eff = {5'd0, frame_height_q};
	end

	assign px_prod = in_item.pos_x * w_eff;
	assign py_prod = in_item.pos_y * h_eff;
	assign px_idx  = px_prod[28:16];
	assign py_idx  = py_prod[28:16];

	always_comb begin
		if (in_item.op == OP_DEVELOP) begin
			col_c = {6'd0, in_item.pixel_col};
			row_c = {6'd0, in_item.pixel_row};
		end else begin
			col_c = px_idx;
			row_c = py_idx;
		end
		if (col_c > w_eff - 13'd1) col_c = w_eff - 13'd1;
		if (row_c > h_eff - 13'd1) row_c = h_eff - 13'd1;
	end

	assign entry = {in_item.op, row_c[ROW_W-1:0], col_c[COL_W-1:0],
		in_item.red, in_item.green, in_item.blue, in_item.count_delta};
	assign busy  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign push  = start && !busy;

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(q_pop);
		end
	end

	assign q_valid = (cnt_q != '0);
	assign {q_op, q_addr, q_color, q_delta} = fifo_q[rd_ptr_q];

endmodule

// ===== rtl/core/ssab_div.sv =====
// Restoring divider: 32-bit sum by 40-bit total, one quotient bit per cycle
module ssab_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] dividend,
	input  logic [39:0] divisor,
	output logic        done,
	output logic [15:0] quot_sat
);
	logic [31:0] quo_q;
	logic [40:0] rem_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [40:0] trial;

	assign trial = {rem_q[39:0], quo_q[31]} - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= 6'd32;
		end else if (run_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			if (!trial[40]) begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[39:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done     = run_q && (cnt_q == 6'd1) ? 1'b0 : (!run_q);
	assign quot_sat = (quo_q[31:16] != '0) ? 16'hFFFF : quo_q[15:0];

endmodule

// ===== rtl/core/ssab_back.sv =====
// Back end: read-modify-write of pixel sums, total update, develop and clear sweep
module ssab_back #(
	parameter int AW = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  logic [1:0]          q_op,
	input  logic [AW-1:0]       q_addr,
	input  logic [47:0]         q_color,
	input  logic [15:0]         q_delta,
	output logic                q_pop,
	output logic                result_valid,
	output ssab_pkg::out_item_t result
);
	import ssab_pkg::*;

	// addresses are {row, column}, so the store spans every code of the address
	localparam int DEPTH = 1 << AW;

	bk_state_t   state_q, state_d;
	logic [95:0] mem_q [DEPTH];
	logic [95:0] rd_q;
	logic [AW-1:0] addr_q, clr_q;
	logic [47:0] color_q;
	logic [39:0] total_q;
	logic [40:0] tsum;
	logic [1:0]  ch_q;
	logic [1:0]  ch_sel;
	logic        div_go, div_done, div_pend_q;
	logic [15:0] quo;
	logic [31:0] div_in;
	logic [15:0] r_q, g_q;
	logic [32:0] sr, sg, sb;
	logic [95:0] wdata;
	logic        we, rd_en;
	logic [AW-1:0] waddr;
	logic        res_v_q;
	out_item_t   res_q;

	assign sr = {1'b0, rd_q[95:64]} + {17'd0, color_q[47:32]};
	assign sg = {1'b0, rd_q[63:32]} + {17'd0, color_q[31:16]};
	assign sb = {1'b0, rd_q[31:0]}  + {17'd0, color_q[15:0]};

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (rd_en) rd_q <= mem_q[q_addr];
	end

	// a divide launched from the wait state works on the next color
	assign ch_sel = (state_q == BK_DIV) ? ch_q + 2'd1 : ch_q;

	always_comb begin
		unique case (ch_sel)
			2'd0:    div_in = rd_q[95:64];
			2'd1:    div_in = rd_q[63:32];
			default: div_in = rd_q[31:0];
		endcase
	end

	ssab_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(div_in),
		.divisor(total_q), .done(div_done), .quot_sat(quo)
	);

	assign tsum = {1'b0, total_q} + {25'd0, q_delta};

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		rd_en   = 1'b0;
		we      = 1'b0;
		waddr   = addr_q;
		wdata   = {sr[32] ? 32'hFFFFFFFF : sr[31:0], sg[32] ? 32'hFFFFFFFF : sg[31:0],
			sb[32] ? 32'hFFFFFFFF : sb[31:0]};
		div_go  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (op_t'(q_op))
						OP_STORE: begin
							rd_en = 1'b1;
							state_d = BK_WRITE;
						end
						OP_DEVELOP: begin
							rd_en = 1'b1;
							state_d = (total_q == '0) ? BK_IDLE : BK_READ;
						end
						OP_CLEAR: state_d = BK_CLEAR;
						default: state_d = BK_IDLE;
					endcase
				end
			end
			BK_WRITE: begin
				we = 1'b1;
				state_d = BK_IDLE;
			end
			BK_READ: begin
				div_go = 1'b1;
				state_d = BK_DIV;
			end
			BK_DIV: begin
				if (div_done && !div_pend_q) begin
					if (ch_q == 2'd2) state_d = BK_IDLE;
					else div_go = 1'b1;
				end
			end
			BK_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
				wdata = '0;
				if (clr_q == AW'(DEPTH - 1)) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_CLEAR;
			clr_q      <= '0;
			total_q    <= '0;
			ch_q       <= '0;
			div_pend_q <= 1'b0;
			res_v_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			res_v_q    <= 1'b0;
			div_pend_q <= div_go;
			if (state_q == BK_CLEAR) clr_q <= clr_q + 1'b1;
			else clr_q <= '0;
			if (state_q == BK_IDLE && q_valid) begin
				if (op_t'(q_op) == OP_ADD_CNT)
					total_q <= tsum[40] ? 40'hFF_FFFF_FFFF : tsum[39:0];
				else if (op_t'(q_op) == OP_CLEAR) total_q <= '0;
				else if (op_t'(q_op) == OP_DEVELOP && total_q == '0) res_v_q <= 1'b1;
				ch_q <= '0;
			end
			if (state_q == BK_DIV && div_done && !div_pend_q) begin
				ch_q <= ch_q + 2'd1;
				if (ch_q == 2'd2) res_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && q_valid) begin
			addr_q  <= q_addr;
			color_q <= q_color;
			res_q   <= '{red_out: '0, green_out: '0, blue_out: '0, total_was_zero: 1'b1};
		end
		if (state_q == BK_DIV && div_done && !div_pend_q) begin
			unique case (ch_q)
				2'd0: r_q <= quo;
				2'd1: g_q <= quo;
				default: res_q <= '{red_out: r_q, green_out: g_q, blue_out: quo,
					total_was_zero: 1'b0};
			endcase
		end
	end

	assign result_valid = res_v_q;
	assign result       = res_q;

endmodule

// ===== rtl/core/ssab_checker.sv =====
// Port-level checks for the sample splat accumulation buffer
module ssab_port_checks (
	input logic                clk,
	input logic                arst_n,
	input logic                busy,
	input logic                result_valid,
	input ssab_pkg::out_item_t result,
	input logic                cfg_ready
);
	import ssab_pkg::*;

	// zero-total flag forces zero colors
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.total_was_zero |->
		result.red_out == '0 && result.green_out == '0 && result.blue_out == '0)
		else $error("zero total with nonzero color");

	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !$isunknown(result))
		else $error("unknown result fields");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(busy) && !$isunknown(result_valid))
		else $error("unknown handshake");

endmodule

bind sample_splat_accumulation_buffer ssab_port_checks u_chk (
	.clk(clk), .arst_n(arst_n), .busy(busy),
	.result_valid(result_valid), .result(result), .cfg_ready(cfg_ready)
);
